FILE: sv/hbs_pkg.sv
// Package with shared types and codes of the heightmap bilinear sampler.
`timescale 1ns / 1ps
package hbs_pkg;

  typedef enum logic [1:0] {
    FUNC_WRITE_CELL  = 2'd0,
    FUNC_WRITE_WORLD = 2'd1,
    FUNC_READ_CELL   = 2'd2,
    FUNC_QUERY       = 2'd3
  } func_t;

  typedef enum logic [2:0] {
    CFG_ORIGIN_X = 3'd0,
    CFG_ORIGIN_Z = 3'd1,
    CFG_CPU_X    = 3'd2,
    CFG_CPU_Z    = 3'd3,
    CFG_GRID_W   = 3'd4,
    CFG_GRID_H   = 3'd5
  } cfg_idx_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MUL,
    ST_CHECK,
    ST_RD0,
    ST_RD1,
    ST_RD2,
    ST_RD3,
    ST_LERPX,
    ST_LERPZ,
    ST_OUT
  } state_t;

  // Interpolate a to b by t/256, rounding the step toward minus infinity.
  function automatic logic signed [15:0] lerp8(input logic signed [15:0] a,
                                              input logic signed [15:0] b,
                                              input logic [7:0] t);
    logic signed [16:0] d;
    logic signed [25:0] p;
    logic signed [17:0] s;
    begin
      d = 17'(b) - 17'(a);
      p = 26'(d) * $signed({18'd0, t});
      s = 18'(a) + 18'(p >>> 8);
      lerp8 = s[15:0];
    end
  endfunction

endpackage

FILE: sv/heightmap_bilinear_sampler_core.sv
// Top level: grid height memory with cell access and bilinear world queries.
`timescale 1ns / 1ps
// Heightmap sampler: one transaction at a time. Every transaction passes
// through a mapping state (ST_MUL), a range check state (ST_CHECK) and the
// memory states ST_RD0 to ST_RD3; a query hit then passes through the lerp
// states ST_LERPX and ST_LERPZ before its result is presented in ST_OUT.
// The single-port height memory serves the four neighbor reads one per
// cycle. A result is held until accepted, and the block takes a new
// transaction in the cycle after that, once it is back in idle.
// The memory has no reset; a read of a never-written cell returns garbage.
module heightmap_bilinear_sampler_core import hbs_pkg::*; #(
  parameter int MAX_COLUMNS = 256,
  parameter int MAX_ROWS    = 256
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         in_func,
  input  logic [7:0]         in_cell_x,
  input  logic [7:0]         in_cell_z,
  input  logic signed [31:0] in_world_x,
  input  logic signed [31:0] in_world_z,
  input  logic signed [15:0] in_height_in,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [15:0] out_height_out,
  output logic               out_ok,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [2:0]         cfg_index,
  input  logic [31:0]        cfg_data
);

  localparam int DEPTH = MAX_COLUMNS * MAX_ROWS;
  localparam int AW    = $clog2(DEPTH);

  state_t state_r, state_nxt;

  // Configuration registers
  logic signed [31:0] org_x_r, org_z_r;
  logic [31:0]        cpu_x_r, cpu_z_r;
  logic [8:0]         gw_r, gh_r;

  // Captured transaction
  func_t              func_r;
  logic [7:0]         cx_r, cz_r;
  logic signed [15:0] hin_r;

  // Mapping results
  logic signed [32:0] dx_r, dz_r;
  logic [63:0]        px_r, pz_r;
  logic               negx_r, negz_r;
  logic [7:0]         fx_r, fz_r;
  logic [12:0]        w_r, h_r;
  logic [AW-1:0]      base_r;

  logic signed [15:0] h00_r, h01_r, h10_r;
  logic signed [15:0] lx0_r, lx1_r;
  logic signed [15:0] res_r;
  logic               ok_r;

  // Height memory
  logic [15:0]   mem [DEPTH];
  logic [15:0]   rdata_r;
  logic          mem_we;
  logic [AW-1:0] mem_addr;

  logic acc_in;
  logic is_query;
  assign acc_in    = in_valid && in_ready;
  assign cfg_ready = 1'b1;
  assign is_query  = (func_r == FUNC_QUERY);

  // Effective sizes
  logic [12:0] w_eff, h_eff;
  assign w_eff = (13'(gw_r) < 13'(MAX_COLUMNS)) ? 13'(gw_r) : 13'(MAX_COLUMNS);
  assign h_eff = (13'(gh_r) < 13'(MAX_ROWS)) ? 13'(gh_r) : 13'(MAX_ROWS);

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:  if (acc_in) state_nxt = ST_MUL;
      ST_MUL:   state_nxt = ST_CHECK;
      ST_CHECK: state_nxt = ST_RD0;
      ST_RD0:   state_nxt = ST_RD1;
      ST_RD1:   state_nxt = ST_RD2;
      ST_RD2:   state_nxt = ST_RD3;
      ST_RD3:   state_nxt = (func_r == FUNC_QUERY && ok_r) ? ST_LERPX : ST_OUT;
      ST_LERPX: state_nxt = ST_LERPZ;
      ST_LERPZ: state_nxt = ST_OUT;
      ST_OUT:   if (out_ready) state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  // Outputs and memory port control; cell operations stay on the base entry
  always_comb begin
    in_ready  = (state_r == ST_IDLE);
    out_valid = (state_r == ST_OUT);
    mem_we    = 1'b0;
    mem_addr  = base_r;
    unique case (state_r)
      ST_RD0: mem_addr = base_r;
      ST_RD1: if (is_query) mem_addr = AW'(base_r + AW'(1));
      ST_RD2: if (is_query) mem_addr = AW'(base_r + AW'(w_r));
      ST_RD3: begin
        if (is_query) mem_addr = AW'(base_r + AW'(w_r) + AW'(1));
        mem_we = ok_r && (func_r == FUNC_WRITE_CELL || func_r == FUNC_WRITE_WORLD);
      end
      default: mem_addr = base_r;
    endcase
  end
  assign out_height_out = res_r;
  assign out_ok         = ok_r;

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_addr] <= hin_r;
    rdata_r <= mem[mem_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      org_x_r <= '0;
      org_z_r <= '0;
      cpu_x_r <= 32'd65536;
      cpu_z_r <= 32'd65536;
      gw_r    <= 9'd256;
      gh_r    <= 9'd256;
    end else begin
      state_r <= state_nxt;
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          CFG_ORIGIN_X: org_x_r <= cfg_data;
          CFG_ORIGIN_Z: org_z_r <= cfg_data;
          CFG_CPU_X:    cpu_x_r <= cfg_data;
          CFG_CPU_Z:    cpu_z_r <= cfg_data;
          CFG_GRID_W:   gw_r    <= cfg_data[8:0];
          CFG_GRID_H:   gh_r    <= cfg_data[8:0];
          default:      ;
        endcase
      end
    end
  end

  // Datapath
  always_ff @(posedge clk) begin
    unique case (state_r)
      ST_IDLE: begin
        // Capture the transaction and the offsets from the grid corner
        func_r <= func_t'(in_func);
        cx_r   <= in_cell_x;
        cz_r   <= in_cell_z;
        hin_r  <= in_height_in;
        dx_r   <= 33'(in_world_x) - 33'(org_x_r);
        dz_r   <= 33'(in_world_z) - 33'(org_z_r);
        w_r    <= w_eff;
        h_r    <= h_eff;
      end
      ST_MUL: begin
        // Scale offsets into grid coordinates (32 x 32 unsigned product)
        negx_r <= dx_r[32] && (cpu_x_r != '0);
        negz_r <= dz_r[32] && (cpu_z_r != '0);
        px_r   <= dx_r[32] ? 64'd0 : 64'(dx_r[31:0]) * 64'(cpu_x_r);
        pz_r   <= dz_r[32] ? 64'd0 : 64'(dz_r[31:0]) * 64'(cpu_z_r);
      end
      ST_CHECK: begin
        // Range check and base address
        fx_r <= px_r[31:24];
        fz_r <= pz_r[31:24];
        if (func_r == FUNC_WRITE_CELL || func_r == FUNC_READ_CELL) begin
          ok_r   <= (13'(cx_r) < w_r) && (13'(cz_r) < h_r);
          base_r <= AW'(cx_r) + AW'(32'(cz_r) * 32'(w_r));
        end else begin
          ok_r  <= !negx_r && !negz_r && (px_r[63:32] < 32'(w_r))
                   && (pz_r[63:32] < 32'(h_r))
                   && (func_r == FUNC_WRITE_WORLD ||
                       ((33'(px_r[63:32]) + 33'd1 < 33'(w_r))
                        && (33'(pz_r[63:32]) + 33'd1 < 33'(h_r))));
          base_r <= AW'(px_r[44:32]) + AW'(32'(pz_r[44:32]) * 32'(w_r));
        end
      end
      ST_RD1: h00_r <= rdata_r;
      ST_RD2: h01_r <= rdata_r;
      ST_RD3: begin
        h10_r <= rdata_r;
        // Cell read result or zero for writes and misses
        if (!(func_r == FUNC_QUERY && ok_r)) begin
          res_r <= (func_r == FUNC_READ_CELL && ok_r) ? rdata_r : '0;
        end
      end
      ST_LERPX: begin
        lx0_r <= lerp8(h00_r, h01_r, fx_r);
        lx1_r <= lerp8(h10_r, rdata_r, fx_r);
      end
      ST_LERPZ: res_r <= lerp8(lx0_r, lx1_r, fz_r);
      ST_OUT: ;
      default: ;
    endcase
  end

`ifndef SYNTHESIS
  a_one_hot_hs: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_ready && out_valid)) else $error("input and output both open");
  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ok && func_r == FUNC_QUERY) |-> (out_height_out == '0))
    else $error("miss with nonzero height");
  a_no_write_on_miss: assert property (@(posedge clk) disable iff (!rst_n)
    mem_we |-> ok_r) else $error("write on miss");
  a_hold_out: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> out_valid) else $error("result dropped");
`endif

endmodule

FILE: tb/sv/tb_heightmap_bilinear_sampler_core.sv
// Testbench for the heightmap bilinear sampler core: cell and world accesses, queries.
`timescale 1ns / 1ps
module tb_heightmap_bilinear_sampler_core;
  import hbs_pkg::*;

  typedef struct {
    func_t              fn;
    logic [7:0]         cx;
    logic [7:0]         cz;
    logic signed [31:0] wx;
    logic signed [31:0] wz;
    logic signed [15:0] hin;
    logic signed [15:0] exp_height;
    logic               exp_ok;
  } sample_txn_t;

  typedef struct {
    logic signed [15:0] height;
    logic               ok;
  } sample_result_t;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic [1:0]         in_func = '0;
  logic [7:0]         in_cell_x = '0;
  logic [7:0]         in_cell_z = '0;
  logic signed [31:0] in_world_x = '0;
  logic signed [31:0] in_world_z = '0;
  logic signed [15:0] in_height_in = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic signed [15:0] out_height_out;
  logic               out_ok;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic [2:0]         cfg_index = '0;
  logic [31:0]        cfg_data = '0;

  heightmap_bilinear_sampler_core uut (.*);

  always #4 clk = ~clk;

  // Shadow copy of the block's registers and height memory
  logic signed [31:0] sh_org_x = 0, sh_org_z = 0;
  logic [31:0]        sh_cpu_x = 32'h10000, sh_cpu_z = 32'h10000;
  logic [8:0]         sh_grid_w = 9'd256, sh_grid_h = 9'd256;
  logic [15:0]        sh_heights [65536];
  bit                 sh_written [65536];

  sample_txn_t    pending_txns[$];
  sample_result_t expected_results[$];
  sample_txn_t    cur_txn;
  bit             in_hold = 0;
  int             send_idle_pct = 37, recv_idle_pct = 84;
  int             n_items = 0, n_results = 0, n_errors = 0, n_hits = 0, stall_cycles = 0;
  int             query_hits = 0;

  function automatic int eff_w();
    return (sh_grid_w < 256) ? int'(sh_grid_w) : 256;
  endfunction

  function automatic int eff_h();
    return (sh_grid_h < 256) ? int'(sh_grid_h) : 256;
  endfunction

  // Map one world axis into a grid index and an 8-bit fraction
  function automatic bit map_world(input logic signed [31:0] wv, input logic signed [31:0] org,
                                   input logic [31:0] scale, output logic [31:0] idx,
                                   output logic [7:0] frac);
    longint     diff;
    logic [63:0] prod;
    diff = longint'(wv) - longint'(org);
    if (diff < 0) begin
      if (scale != 0) return 0;
      prod = '0;
    end else begin
      prod = 64'(diff) * 64'(scale);
    end
    idx = prod[63:32];
    frac = prod[31:24];
    return 1;
  endfunction

  function automatic int lerp_q8(input int a, input int b, input int t);
    int p;
    p = (b - a) * t;
    return a + (p >>> 8);
  endfunction

  // Work out the result of one transaction; flag reads of unwritten cells
  function automatic sample_txn_t predict_sample(input sample_txn_t t, output bit unsafe);
    int          w, h, addr, x0, z0;
    logic [31:0] ix, iz;
    logic [7:0]  fx, fz;
    bit          inx, inz;
    int          a00, a01, a10, a11;
    w = eff_w();
    h = eff_h();
    unsafe = 0;
    t.exp_height = '0;
    t.exp_ok = 1'b0;
    if (t.fn == FUNC_WRITE_CELL || t.fn == FUNC_READ_CELL) begin
      if (t.cx < w && t.cz < h) begin
        addr = t.cx + t.cz * w;
        if (t.fn == FUNC_WRITE_CELL) begin
          sh_heights[addr] = t.hin;
          sh_written[addr] = 1;
        end else if (!sh_written[addr]) begin
          unsafe = 1;
          return t;
        end else begin
          t.exp_height = sh_heights[addr];
        end
        t.exp_ok = 1'b1;
      end
    end else begin
      inx = map_world(t.wx, sh_org_x, sh_cpu_x, ix, fx);
      inz = map_world(t.wz, sh_org_z, sh_cpu_z, iz, fz);
      if (inx && inz && ix < w && iz < h) begin
        x0 = int'(ix);
        z0 = int'(iz);
        if (t.fn == FUNC_WRITE_WORLD) begin
          sh_heights[x0 + z0 * w] = t.hin;
          sh_written[x0 + z0 * w] = 1;
          t.exp_ok = 1'b1;
        end else if (x0 + 1 < w && z0 + 1 < h) begin
          a00 = x0 + z0 * w;
          a01 = a00 + 1;
          a10 = a00 + w;
          a11 = a10 + 1;
          if (!(sh_written[a00] && sh_written[a01] && sh_written[a10] && sh_written[a11])) begin
            unsafe = 1;
            return t;
          end
          t.exp_height = 16'(lerp_q8(
              lerp_q8($signed(sh_heights[a00]), $signed(sh_heights[a01]), fx),
              lerp_q8($signed(sh_heights[a10]), $signed(sh_heights[a11]), fx), fz));
          t.exp_ok = 1'b1;
        end
      end
    end
    return t;
  endfunction

  // Predict and queue one transaction; unsafe reads become writes
  task automatic queue_sample(input func_t fn, input int cx, input int cz,
                              input logic [31:0] wx, input logic [31:0] wz,
                              input logic [15:0] hin);
    sample_txn_t t;
    bit          unsafe;
    t.fn = fn; t.cx = cx[7:0]; t.cz = cz[7:0];
    t.wx = wx; t.wz = wz; t.hin = hin;
    t = predict_sample(t, unsafe);
    if (unsafe) begin
      t.fn = (t.fn == FUNC_READ_CELL) ? FUNC_WRITE_CELL : FUNC_WRITE_WORLD;
      t = predict_sample(t, unsafe);
    end
    if (t.fn == FUNC_QUERY && t.exp_ok) query_hits++;
    pending_txns.push_back(t);
    n_items++;
  endtask

  // Write one register; the caller must use it only while the block is idle, the task does not enforce it
  task automatic write_reg(input cfg_idx_t idx, input logic [31:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!(cfg_valid && cfg_ready));
    case (idx)
      CFG_ORIGIN_X: sh_org_x = val;
      CFG_ORIGIN_Z: sh_org_z = val;
      CFG_CPU_X:    sh_cpu_x = val;
      CFG_CPU_Z:    sh_cpu_z = val;
      CFG_GRID_W:   sh_grid_w = val[8:0];
      CFG_GRID_H:   sh_grid_h = val[8:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Hold until every transaction has been answered, then let the pipeline settle
  task automatic drain();
    while (pending_txns.size() != 0 || in_hold || expected_results.size() != 0)
      @(posedge clk);
    repeat (12) @(posedge clk);
  endtask

  task automatic set_grid(input logic [31:0] ox, input logic [31:0] oz, input logic [31:0] sx,
                          input logic [31:0] sz, input int w, input int h);
    drain();
    write_reg(CFG_ORIGIN_X, ox);
    write_reg(CFG_ORIGIN_Z, oz);
    write_reg(CFG_CPU_X, sx);
    write_reg(CFG_CPU_Z, sz);
    write_reg(CFG_GRID_W, w);
    write_reg(CFG_GRID_H, h);
  endtask

  // World coordinate that lands near the grid on one axis
  function automatic logic [31:0] near_world(input logic [31:0] org, input logic [31:0] scale,
                                             input int cells);
    longint gq;
    if ($urandom_range(0, 4) == 0 || scale == 0) return $urandom;
    gq = longint'($urandom_range(0, (cells + 1) * 65536)) - 32768;
    return 32'(longint'($signed(org)) + (gq <<< 16) / longint'(scale));
  endfunction

  task automatic random_phase(input int count, input bit fill);
    int w, h, sel;
    w = eff_w();
    h = eff_h();
    if (fill)
      for (int z = 0; z < h; z++)
        for (int x = 0; x < w; x++)
          queue_sample(FUNC_WRITE_CELL, x, z, 0, 0, 16'($urandom));
    repeat (count) begin
      sel = $urandom_range(0, 9);
      if (sel < 2)
        queue_sample(FUNC_WRITE_CELL, ($urandom_range(0, 4) == 0) ? $urandom_range(0, 255) :
                     $urandom_range(0, w + 1), $urandom_range(0, 4) == 0 ?
                     $urandom_range(0, 255) : $urandom_range(0, h + 1), $urandom, $urandom,
                     16'($urandom));
      else if (sel < 4)
        queue_sample(FUNC_READ_CELL, $urandom_range(0, 255) % (w + 2),
                     $urandom_range(0, 255) % (h + 2), $urandom, $urandom, 16'($urandom));
      else
        queue_sample((sel < 6) ? FUNC_WRITE_WORLD : FUNC_QUERY, $urandom, $urandom,
                     near_world(sh_org_x, sh_cpu_x, w), near_world(sh_org_z, sh_cpu_z, h),
                     16'($urandom));
    end
  endtask

  // Drive the input channel from the pending queue
  always @(negedge clk) begin
    if (rst_n && !in_hold) begin
      if (pending_txns.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
        cur_txn = pending_txns.pop_front();
        in_hold = 1;
        in_valid <= 1'b1;
        in_func <= cur_txn.fn;
        in_cell_x <= cur_txn.cx;
        in_cell_z <= cur_txn.cz;
        in_world_x <= cur_txn.wx;
        in_world_z <= cur_txn.wz;
        in_height_in <= cur_txn.hin;
      end else begin
        in_valid <= 1'b0;
      end
    end
    if (rst_n) out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
  end

  // Check results, advance the input handshake, watch for a stuck block
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) begin
        expected_results.push_back('{cur_txn.exp_height, cur_txn.exp_ok});
        in_hold = 0;
      end
      if (out_valid && out_ready) begin
        n_results++;
        if (expected_results.size() == 0) begin
          $display("%0t: unexpected result height=%0d ok=%0b", $time, out_height_out, out_ok);
          n_errors++;
        end else begin
          if (out_height_out !== expected_results[0].height)
            begin
            $display("%0t: height mismatch expected %0d actual %0d", $time,
                     expected_results[0].height, out_height_out);
            n_errors++;
          end
          if (out_ok !== expected_results[0].ok) begin
            $display("%0t: ok mismatch expected %0b actual %0b", $time,
                     expected_results[0].ok, out_ok);
            n_errors++;
          end
          if (expected_results[0].ok) n_hits++;
          void'(expected_results.pop_front());
        end
      end
      if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
        stall_cycles = 0;
      else
        stall_cycles++;
      if (stall_cycles >= 4000) begin
        $display("%0t: no transaction for %0d cycles", $time, stall_cycles);
        $display("TEST FAILED");
        $finish;
      end
    end
  end

  initial begin
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed: extremes, corner cells, edge and negative misses at reset settings
    queue_sample(FUNC_WRITE_CELL, 0, 0, 0, 0, 16'h7FFF);
    queue_sample(FUNC_WRITE_CELL, 1, 0, 0, 0, 16'h8000);
    queue_sample(FUNC_WRITE_CELL, 0, 1, 0, 0, 16'h0100);
    queue_sample(FUNC_WRITE_CELL, 1, 1, 0, 0, 16'hFF00);
    queue_sample(FUNC_WRITE_CELL, 255, 255, 0, 0, 16'h7FFF);
    queue_sample(FUNC_WRITE_CELL, 254, 255, 0, 0, 16'h0000);
    queue_sample(FUNC_WRITE_CELL, 255, 254, 0, 0, 16'h8000);
    queue_sample(FUNC_WRITE_CELL, 254, 254, 0, 0, 16'h1234);
    queue_sample(FUNC_READ_CELL, 0, 0, 0, 0, 0);
    queue_sample(FUNC_READ_CELL, 1, 1, 0, 0, 0);
    queue_sample(FUNC_READ_CELL, 255, 255, 0, 0, 0);
    queue_sample(FUNC_QUERY, 0, 0, 32'h0000_8000, 32'h0000_8000, 0);
    queue_sample(FUNC_QUERY, 0, 0, 32'h0000_FF00, 32'h0000_0100, 0);
    queue_sample(FUNC_QUERY, 0, 0, 32'h0000_0000, 32'h0000_0000, 0);
    queue_sample(FUNC_QUERY, 0, 0, 32'h00FE_C000, 32'h00FE_4000, 0);
    queue_sample(FUNC_QUERY, 0, 0, 32'h00FF_0000, 32'h0000_0000, 0);
    queue_sample(FUNC_QUERY, 0, 0, 32'hFFFF_FFFF, 32'h0000_0000, 0);
    queue_sample(FUNC_QUERY, 0, 0, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 0);
    queue_sample(FUNC_WRITE_WORLD, 0, 0, 32'h0003_B000, 32'h0002_1000, 16'h0ABC);
    queue_sample(FUNC_READ_CELL, 3, 2, 0, 0, 0);
    queue_sample(FUNC_WRITE_WORLD, 0, 0, 32'hFFFF_0000, 32'h0000_0000, 16'h5555);
    queue_sample(FUNC_WRITE_WORLD, 0, 0, 32'h0100_0000, 32'h0000_0000, 16'hAAAA);

    // Sender idles often, receiver mostly stalls
    set_grid(32'h0001_0000, -32'sh0002_8000, 32'h0001_0000, 32'h0001_0000, 16, 16);
    random_phase(100, 1);
    set_grid(32'h8000_0000, -32'sh0005_0000, 32'h0004_0000, 32'hFFFF_FFFF, 2, 256);
    random_phase(60, 1);

    // Roles swapped: sender mostly idle, receiver stalls often
    drain();
    send_idle_pct = 84;
    recv_idle_pct = 37;
    set_grid(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h0000_0000, 32'h0000_0000, 256, 2);
    random_phase(60, 1);
    set_grid(32'h1234_5678, 32'h0ABC_0000, 32'h0000_4000, 32'h0001_8000, 7, 11);
    random_phase(100, 1);

    // Full speed on the full grid
    drain();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    set_grid(32'h0000_0000, 32'h0000_0000, 32'h0001_0000, 32'h0001_0000, 256, 256);
    random_phase(160, 0);
    set_grid(32'hFFF0_0000, 32'hFFF0_0000, 32'h0002_0000, 32'h0000_8000, 5, 3);
    random_phase(76, 1);
    drain();

    $display("Covered %0d transactions over 7 grid settings, %0d results (%0d ok, %0d query hits).",
             n_items, n_results, n_hits, query_hits);
    if (n_errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("%0d mismatches", n_errors);
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
